// ===== rtl/prbe_pkg.sv =====
package prbe_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int MAX_LEVELS = 1024;

    localparam int CMD_W  = 3;
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int LINK_W = $clog2(MAX_NODES + 1);
    localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
    localparam int LIDX_W = $clog2(MAX_LEVELS);
    localparam int CFG_W  = 11;
    localparam int CNT_W  = $clog2(2 * MAX_LEVELS * (MAX_NODES + 1) + 2);

    localparam int SWEEP_N = (MAX_NODES > MAX_LEVELS) ? MAX_NODES : MAX_LEVELS;
    localparam int SW_W    = $clog2(SWEEP_N);

    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_NODES);

    localparam logic CFG_IDX_NODES = 1'b0;
    localparam logic CFG_IDX_INF   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 3'd0,
        CMD_LOAD    = 3'd1,
        CMD_ACT     = 3'd2,
        CMD_DEACT   = 3'd3,
        CMD_RELABEL = 3'd4,
        CMD_PEEK    = 3'd5,
        CMD_RDLVL   = 3'd6,
        CMD_NOP     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        MB_NONE  = 2'd0,
        MB_ACT   = 2'd1,
        MB_INACT = 2'd2
    } t_mbr;

endpackage

// ===== rtl/prbe_in_if.sv =====
interface prbe_in_if;
    logic                         valid;
    logic                         ready;
    logic [prbe_pkg::CMD_W-1:0]   cmd;
    logic [prbe_pkg::NODE_W-1:0]  node;
    logic [prbe_pkg::LVL_W-1:0]   new_level;
    logic                         has_excess;

    modport source (output valid, cmd, node, new_level, has_excess, input ready);
    modport sink   (input valid, cmd, node, new_level, has_excess, output ready);
endinterface

// ===== rtl/prbe_out_if.sv =====
interface prbe_out_if;
    logic                         valid;
    logic                         ready;
    logic [prbe_pkg::NODE_W-1:0]  max_active_node;
    logic                         empty_res;
    logic                         any_active;
    logic [prbe_pkg::LVL_W-1:0]   removed_count;
    logic [prbe_pkg::LVL_W-1:0]   level_value;
    logic [prbe_pkg::LVL_W-1:0]   included_count;

    modport source (output valid, max_active_node, empty_res, any_active, removed_count,
                    level_value, included_count, input ready);
    modport sink   (input valid, max_active_node, empty_res, any_active, removed_count,
                    level_value, included_count, output ready);
endinterface

// ===== rtl/prbe_ram.sv =====
module prbe_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [W-1:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [W-1:0]               o_rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== rtl/push_relabel_bucket_engine_core.sv =====
// bucket engine for highest-label push-relabel max flow
// i_in carries one command per transfer (clear, load, activate, deactivate,
// relabel, peek, read level); o_out returns exactly one result per command.
// i_cfg_we/i_cfg_idx/i_cfg_wdata write node_count (0) and infinity_level (1);
// write them only while no command is in flight.
// one command is worked at a time by a sequencer over six memories, each
// with one write port and one registered read port (next/prev links, node
// level, membership, active/inactive heads); every step waits on the previous read.
// a deactivate rescans down past empty levels for the new top active level;
// a relabel that leaves a gap wipes every node on the levels above the gap
// and may then rescan the top. clear and reset run a sweep wiping the heads
// and membership; i_in.ready stays low during it. a clear then puts the
// sink into the inactive list at level 0.
// the result sits in an output register; a stalled receiver only holds the
// next command at its final step, input is taken again once it is sent
module push_relabel_bucket_engine_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    prbe_in_if.sink                         i_in,
    prbe_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [prbe_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import prbe_pkg::*;

    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_SWEEP = 20'h00002,
        ST_CLRF  = 20'h00004,
        ST_DEC   = 20'h00008,
        ST_PEEK  = 20'h00010,
        ST_U1    = 20'h00020,
        ST_U2    = 20'h00040,
        ST_P1    = 20'h00080,
        ST_P2    = 20'h00100,
        ST_P3    = 20'h00200,
        ST_R1    = 20'h00400,
        ST_R2    = 20'h00800,
        ST_G0    = 20'h01000,
        ST_G1    = 20'h02000,
        ST_W0    = 20'h04000,
        ST_W1    = 20'h08000,
        ST_W2    = 20'h10000,
        ST_W3    = 20'h20000,
        ST_WEND  = 20'h40000,
        ST_DONE  = 20'h80000
    } t_state;

    // memory ports
    logic              nxt_we, prv_we, lvl_we, mbr_we, ahd_we, ihd_we;
    logic [LINK_W-1:0] nxt_wa, nxt_ra, prv_wa, prv_ra;
    logic [LINK_W-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd;
    logic [NODE_W-1:0] lvl_wa, lvl_ra, mbr_wa, mbr_ra;
    logic [LVL_W-1:0]  lvl_wd, lvl_rd;
    logic [1:0]        mbr_wd, mbr_rd;
    logic [LIDX_W-1:0] ahd_wa, ahd_ra, ihd_wa, ihd_ra;
    logic [LINK_W-1:0] ahd_wd, ahd_rd, ihd_wd, ihd_rd;

    t_state            r_state, n_state;
    logic [SW_W-1:0]   r_sw, n_sw;
    logic              r_clr, n_clr;
    t_cmd              r_cmd, n_cmd;
    logic [NODE_W-1:0] r_u, n_u;
    logic [LVL_W-1:0]  r_nl, n_nl;
    logic              r_ex, n_ex;
    logic [LVL_W-1:0]  r_lv, n_lv;
    logic              r_pact, n_pact;
    logic [LIDX_W-1:0] r_pd, n_pd;
    logic [NODE_W-1:0] r_pi, n_pi;
    logic [LINK_W-1:0] r_hd, n_hd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [LVL_W-1:0]  r_wl, n_wl;
    logic [LINK_W-1:0] r_wi, n_wi;
    logic [LINK_W-1:0] r_ih, n_ih;
    logic              r_wph, n_wph;
    logic [LINK_W-1:0] r_st, n_st;
    logic [LVL_W-1:0]  r_tact1, n_tact1;
    logic [LVL_W-1:0]  r_tused1, n_tused1;
    logic [LVL_W-1:0]  r_incl, n_incl;
    logic [LVL_W-1:0]  r_rem, n_rem;
    logic [NODE_W-1:0] r_peek, n_peek;
    logic              r_empty, n_empty;
    logic [LVL_W-1:0]  r_lvo, n_lvo;
    logic [CFG_W-1:0]  r_cfg_n, r_cfg_inf;
    logic              r_ovalid, n_ovalid;
    logic              r_o_load;
    logic [NODE_W-1:0] r_o_peek;
    logic              r_o_empty, r_o_any;
    logic [LVL_W-1:0]  r_o_rem, r_o_lvo, r_o_incl;

    logic [CFG_W-1:0]  w_n, w_inf;
    logic [NODE_W-1:0] w_sink;
    logic              w_fire, w_done;
    logic [LINK_W-1:0] w_hd_p, w_hd_u;
    logic              w_ulist_act;
    logic [LVL_W-1:0]  w_pd1, w_tmax, w_nl1;

    assign w_n = (r_cfg_n < CFG_W'(2)) ? CFG_W'(2) :
                 (r_cfg_n > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : r_cfg_n;
    assign w_inf = (r_cfg_inf < CFG_W'(1)) ? CFG_W'(1) :
                   (r_cfg_inf > CFG_W'(MAX_LEVELS)) ? CFG_W'(MAX_LEVELS) : r_cfg_inf;
    assign w_sink = NODE_W'(w_n - CFG_W'(1));

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_fire      = i_in.valid && (r_state == ST_IDLE);
    assign w_ulist_act = (r_cmd == CMD_DEACT);
    assign w_hd_p      = r_pact ? ahd_rd : ihd_rd;
    assign w_hd_u      = w_ulist_act ? ahd_rd : ihd_rd;
    assign w_pd1       = LVL_W'(r_pd) + LVL_W'(1);
    assign w_tmax      = (w_pd1 > r_tact1) ? w_pd1 : r_tact1;
    assign w_nl1       = r_nl + LVL_W'(1);
    assign w_done      = (r_state == ST_DONE) && (!r_ovalid || o_out.ready);

    always_comb begin
        n_state  = r_state;
        n_sw     = r_sw;
        n_clr    = r_clr;
        n_cmd    = r_cmd;
        n_u      = r_u;
        n_nl     = r_nl;
        n_ex     = r_ex;
        n_lv     = r_lv;
        n_pact   = r_pact;
        n_pd     = r_pd;
        n_pi     = r_pi;
        n_hd     = r_hd;
        n_cnt    = r_cnt;
        n_wl     = r_wl;
        n_wi     = r_wi;
        n_ih     = r_ih;
        n_wph    = r_wph;
        n_st     = r_st;
        n_tact1  = r_tact1;
        n_tused1 = r_tused1;
        n_incl   = r_incl;
        n_rem    = r_rem;
        n_peek   = r_peek;
        n_empty  = r_empty;
        n_lvo    = r_lvo;

        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = LINK_W'(r_u);
        prv_we = 1'b0; prv_wa = '0; prv_wd = '0; prv_ra = LINK_W'(r_u);
        lvl_we = 1'b0; lvl_wa = r_u; lvl_wd = '0; lvl_ra = r_u;
        mbr_we = 1'b0; mbr_wa = r_u; mbr_wd = MB_NONE; mbr_ra = r_u;
        ahd_we = 1'b0; ahd_wa = '0; ahd_wd = END_MARK; ahd_ra = r_lv[LIDX_W-1:0];
        ihd_we = 1'b0; ihd_wa = '0; ihd_wd = END_MARK; ihd_ra = r_lv[LIDX_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    n_cmd   = t_cmd'(i_in.cmd);
                    n_u     = i_in.node;
                    n_nl    = i_in.new_level;
                    n_ex    = i_in.has_excess;
                    n_rem   = '0;
                    n_peek  = '0;
                    n_empty = 1'b0;
                    n_lvo   = '0;
                    lvl_ra  = i_in.node;
                    mbr_ra  = i_in.node;
                    unique case (t_cmd'(i_in.cmd))
                        CMD_CLEAR: begin
                            n_clr   = 1'b1;
                            n_sw    = '0;
                            n_state = ST_SWEEP;
                        end
                        CMD_PEEK: begin
                            ahd_ra = LIDX_W'(r_tact1 - LVL_W'(1));
                            if (r_tact1 != '0) begin
                                n_state = ST_PEEK;
                            end else begin
                                n_empty = 1'b1;
                                n_state = ST_DONE;
                            end
                        end
                        CMD_NOP: n_state = ST_DONE;
                        default: begin
                            if (CFG_W'(i_in.node) < w_n) n_state = ST_DEC;
                            else n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                ahd_we = (LVL_W'(r_sw) < LVL_W'(MAX_LEVELS));
                ihd_we = ahd_we;
                ahd_wa = LIDX_W'(r_sw);
                ihd_wa = LIDX_W'(r_sw);
                mbr_we = (LINK_W'(r_sw) < LINK_W'(MAX_NODES));
                mbr_wa = NODE_W'(r_sw);
                mbr_wd = MB_NONE;
                if (r_sw == SW_W'(SWEEP_N - 1)) begin
                    n_sw    = '0;
                    n_state = r_clr ? ST_CLRF : ST_IDLE;
                end else begin
                    n_sw = r_sw + SW_W'(1);
                end
            end
            ST_CLRF: begin
                // sink goes in inactive at level 0
                lvl_we   = 1'b1;
                lvl_wa   = w_sink;
                lvl_wd   = '0;
                n_tact1  = '0;
                n_tused1 = '0;
                n_incl   = LVL_W'(2);
                n_pact   = 1'b0;
                n_pd     = '0;
                n_pi     = w_sink;
                n_clr    = 1'b0;
                n_state  = ST_P1;
            end
            ST_DEC: begin
                n_lv    = lvl_rd;
                n_pi    = r_u;
                n_state = ST_DONE;
                unique case (r_cmd)
                    CMD_LOAD: begin
                        if ((CFG_W'(r_u) + CFG_W'(2) < w_n) && (mbr_rd == MB_NONE)) begin
                            lvl_we = 1'b1;
                            lvl_wd = r_nl;
                            if (r_nl < w_inf) begin
                                n_incl = r_incl + LVL_W'(1);
                                if (w_nl1 > r_tused1) n_tused1 = w_nl1;
                                n_pact  = r_ex;
                                n_pd    = r_nl[LIDX_W-1:0];
                                n_state = ST_P1;
                            end
                        end
                    end
                    CMD_ACT: begin
                        if (mbr_rd == MB_INACT) begin
                            n_pact  = 1'b1;
                            n_pd    = lvl_rd[LIDX_W-1:0];
                            n_state = ST_U1;
                        end
                    end
                    CMD_DEACT: begin
                        if (mbr_rd == MB_ACT) begin
                            n_pact  = 1'b0;
                            n_pd    = lvl_rd[LIDX_W-1:0];
                            n_state = ST_U1;
                        end
                    end
                    CMD_RELABEL: begin
                        if (mbr_rd == MB_INACT) begin
                            lvl_we  = 1'b1;
                            lvl_wd  = r_nl;
                            mbr_we  = 1'b1;
                            mbr_wd  = MB_NONE;
                            n_pact  = 1'b0;
                            n_pd    = r_nl[LIDX_W-1:0];
                            n_state = ST_U1;
                        end
                    end
                    CMD_RDLVL: n_lvo = lvl_rd;
                    default: n_state = ST_DONE;
                endcase
            end
            ST_PEEK: begin
                if (ahd_rd != END_MARK) n_peek = ahd_rd[NODE_W-1:0];
                else n_empty = 1'b1;
                n_state = ST_DONE;
            end
            ST_U1: begin
                n_state = ST_U2;
            end
            ST_U2: begin
                // splice the node out of its list
                if (w_hd_u == LINK_W'(r_u)) begin
                    prv_we = 1'b1;
                    prv_wa = nxt_rd;
                    prv_wd = END_MARK;
                    ahd_we = w_ulist_act;
                    ihd_we = !w_ulist_act;
                    ahd_wa = r_lv[LIDX_W-1:0];
                    ihd_wa = r_lv[LIDX_W-1:0];
                    ahd_wd = nxt_rd;
                    ihd_wd = nxt_rd;
                end else begin
                    nxt_we = 1'b1;
                    nxt_wa = prv_rd;
                    nxt_wd = nxt_rd;
                    prv_we = 1'b1;
                    prv_wa = nxt_rd;
                    prv_wd = prv_rd;
                end
                priority case (r_cmd)
                    CMD_ACT:   n_state = ST_P1;
                    CMD_DEACT: n_state = ST_R1;
                    default:   n_state = ST_G0;
                endcase
            end
            ST_P1: begin
                ahd_ra  = r_pd;
                ihd_ra  = r_pd;
                n_state = ST_P2;
            end
            ST_P2: begin
                n_hd    = w_hd_p;
                nxt_we  = 1'b1;
                nxt_wa  = LINK_W'(r_pi);
                nxt_wd  = w_hd_p;
                prv_we  = 1'b1;
                prv_wa  = LINK_W'(r_pi);
                prv_wd  = END_MARK;
                n_state = ST_P3;
            end
            ST_P3: begin
                prv_we = 1'b1;
                prv_wa = r_hd;
                prv_wd = LINK_W'(r_pi);
                ahd_we = r_pact;
                ihd_we = !r_pact;
                ahd_wa = r_pd;
                ihd_wa = r_pd;
                ahd_wd = LINK_W'(r_pi);
                ihd_wd = LINK_W'(r_pi);
                mbr_we = 1'b1;
                mbr_wa = r_pi;
                mbr_wd = r_pact ? MB_ACT : MB_INACT;
                if (r_pact) begin
                    n_tact1 = w_tmax;
                    if (w_tmax > r_tused1) n_tused1 = w_tmax;
                end
                n_state = ST_DONE;
            end
            ST_R1: begin
                ahd_ra = LIDX_W'(r_tact1 - LVL_W'(1));
                if (r_tact1 != '0) n_state = ST_R2;
                else n_state = (r_cmd == CMD_DEACT) ? ST_P1 : ST_DONE;
            end
            ST_R2: begin
                if (ahd_rd == END_MARK) begin
                    n_tact1 = r_tact1 - LVL_W'(1);
                    n_state = ST_R1;
                end else begin
                    n_state = (r_cmd == CMD_DEACT) ? ST_P1 : ST_DONE;
                end
            end
            ST_G0: begin
                n_state = ST_G1;
            end
            ST_G1: begin
                if ((ahd_rd == END_MARK) && (ihd_rd == END_MARK)) begin
                    // gap: the relabeled node and everything above go to infinity
                    lvl_we  = 1'b1;
                    lvl_wd  = LVL_W'(w_inf);
                    n_cnt   = CNT_W'(1);
                    n_wl    = r_lv + LVL_W'(1);
                    n_state = ST_W0;
                end else if (r_nl < w_inf) begin
                    if (w_nl1 > r_tused1) n_tused1 = w_nl1;
                    n_state = ST_P1;
                end else begin
                    if (r_incl != '0) n_incl = r_incl - LVL_W'(1);
                    n_state = ST_DONE;
                end
            end
            ST_W0: begin
                ahd_ra = r_wl[LIDX_W-1:0];
                ihd_ra = r_wl[LIDX_W-1:0];
                if ((r_wl < r_tused1) && (r_wl < LVL_W'(MAX_LEVELS))) n_state = ST_W1;
                else n_state = ST_WEND;
            end
            ST_W1: begin
                n_wi    = ahd_rd;
                n_ih    = ihd_rd;
                n_wph   = 1'b0;
                n_st    = '0;
                ahd_we  = 1'b1;
                ihd_we  = 1'b1;
                ahd_wa  = r_wl[LIDX_W-1:0];
                ihd_wa  = r_wl[LIDX_W-1:0];
                n_state = ST_W2;
            end
            ST_W2: begin
                nxt_ra = r_wi;
                if ((r_wi == END_MARK) || (r_st > LINK_W'(MAX_NODES))) begin
                    if (!r_wph) begin
                        n_wph = 1'b1;
                        n_wi  = r_ih;
                        n_st  = '0;
                    end else begin
                        n_wl    = r_wl + LVL_W'(1);
                        n_state = ST_W0;
                    end
                end else begin
                    lvl_we  = 1'b1;
                    lvl_wa  = r_wi[NODE_W-1:0];
                    lvl_wd  = LVL_W'(w_inf);
                    mbr_we  = 1'b1;
                    mbr_wa  = r_wi[NODE_W-1:0];
                    mbr_wd  = MB_NONE;
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_st    = r_st + LINK_W'(1);
                    n_state = ST_W3;
                end
            end
            ST_W3: begin
                n_wi    = nxt_rd;
                n_state = ST_W2;
            end
            ST_WEND: begin
                n_tused1 = r_lv;
                n_rem    = r_cnt[LVL_W-1:0];
                if (r_cnt > CNT_W'(r_incl)) n_incl = '0;
                else n_incl = r_incl - r_cnt[LVL_W-1:0];
                if (r_tact1 >= r_lv) begin
                    n_tact1 = r_lv;
                    n_state = ST_R1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_ovalid = (r_ovalid && !o_out.ready) || w_done;
    assign r_o_load = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SWEEP;
            r_sw      <= '0;
            r_clr     <= 1'b0;
            r_tact1   <= '0;
            r_tused1  <= '0;
            r_incl    <= LVL_W'(2);
            r_cfg_n   <= CFG_W'(MAX_NODES);
            r_cfg_inf <= CFG_W'(MAX_LEVELS);
            r_ovalid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sw     <= n_sw;
            r_clr    <= n_clr;
            r_tact1  <= n_tact1;
            r_tused1 <= n_tused1;
            r_incl   <= n_incl;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_NODES) r_cfg_n <= i_cfg_wdata;
                else r_cfg_inf <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_u     <= n_u;
        r_nl    <= n_nl;
        r_ex    <= n_ex;
        r_lv    <= n_lv;
        r_pact  <= n_pact;
        r_pd    <= n_pd;
        r_pi    <= n_pi;
        r_hd    <= n_hd;
        r_cnt   <= n_cnt;
        r_wl    <= n_wl;
        r_wi    <= n_wi;
        r_ih    <= n_ih;
        r_wph   <= n_wph;
        r_st    <= n_st;
        r_rem   <= n_rem;
        r_peek  <= n_peek;
        r_empty <= n_empty;
        r_lvo   <= n_lvo;
        if (r_o_load) begin
            r_o_peek  <= r_peek;
            r_o_empty <= r_empty;
            r_o_any   <= (r_tact1 > LVL_W'(1));
            r_o_rem   <= r_rem;
            r_o_lvo   <= r_lvo;
            r_o_incl  <= r_incl;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.max_active_node = r_o_peek;
    assign o_out.empty_res       = r_o_empty;
    assign o_out.any_active      = r_o_any;
    assign o_out.removed_count   = r_o_rem;
    assign o_out.level_value     = r_o_lvo;
    assign o_out.included_count  = r_o_incl;

    prbe_ram #(.W(LINK_W), .DEPTH(MAX_NODES + 1)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(nxt_ra), .o_rdata(nxt_rd)
    );
    prbe_ram #(.W(LINK_W), .DEPTH(MAX_NODES + 1)) u_prv (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(prv_ra), .o_rdata(prv_rd)
    );
    prbe_ram #(.W(LVL_W), .DEPTH(MAX_NODES)) u_lvl (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(lvl_wa), .i_wdata(lvl_wd),
        .i_raddr(lvl_ra), .o_rdata(lvl_rd)
    );
    prbe_ram #(.W(2), .DEPTH(MAX_NODES)) u_mbr (
        .i_clk(i_clk), .i_we(mbr_we), .i_waddr(mbr_wa), .i_wdata(mbr_wd),
        .i_raddr(mbr_ra), .o_rdata(mbr_rd)
    );
    prbe_ram #(.W(LINK_W), .DEPTH(MAX_LEVELS)) u_ahd (
        .i_clk(i_clk), .i_we(ahd_we), .i_waddr(ahd_wa), .i_wdata(ahd_wd),
        .i_raddr(ahd_ra), .o_rdata(ahd_rd)
    );
    prbe_ram #(.W(LINK_W), .DEPTH(MAX_LEVELS)) u_ihd (
        .i_clk(i_clk), .i_we(ihd_we), .i_waddr(ihd_wa), .i_wdata(ihd_wd),
        .i_raddr(ihd_ra), .o_rdata(ihd_rd)
    );
endmodule

// ===== dv/tb_push_relabel_bucket_engine_core.sv =====
class prbe_scoreboard;
    typedef struct packed {
        logic [prbe_pkg::NODE_W-1:0] max_active_node;
        logic                        empty_res;
        logic                        any_active;
        logic [prbe_pkg::LVL_W-1:0]  removed_count;
        logic [prbe_pkg::LVL_W-1:0]  level_value;
        logic [prbe_pkg::LVL_W-1:0]  included_count;
    } bucket_result_t;

    localparam int NN = prbe_pkg::MAX_NODES;
    localparam int NL = prbe_pkg::MAX_LEVELS;
    localparam int ENDM = prbe_pkg::MAX_NODES;

    int unsigned      nxt[0:NN];
    int unsigned      prv[0:NN];
    int unsigned      lvl[0:NN-1];
    bit               written[0:NN-1];
    prbe_pkg::t_mbr   mbr[0:NN-1];
    int unsigned      act_head[0:NL-1];
    int unsigned      inact_head[0:NL-1];
    int               top_act;
    int               top_used;
    int               incl;
    int unsigned      cfg_nodes;
    int unsigned      cfg_inf;
    bucket_result_t   expected_results[$];
    int               mismatches;
    int               results_seen;
    int               gaps_seen;
    int               empties_seen;

    function new();
        cfg_nodes = 1024;
        cfg_inf = 1024;
        for (int i = 0; i < NL; i++) begin
            act_head[i] = ENDM;
            inact_head[i] = ENDM;
        end
        for (int i = 0; i < NN; i++) begin
            mbr[i] = prbe_pkg::MB_NONE;
            written[i] = 0;
        end
        top_act = -1;
        top_used = -1;
        incl = 2;
    endfunction

    function int unsigned eff_nodes();
        if (cfg_nodes < 2) return 2;
        if (cfg_nodes > NN) return NN;
        return cfg_nodes;
    endfunction

    function int unsigned eff_inf();
        if (cfg_inf < 1) return 1;
        if (cfg_inf > NL) return NL;
        return cfg_inf;
    endfunction

    function int unsigned head_of(bit act, int d);
        return act ? act_head[d] : inact_head[d];
    endfunction

    function void set_head(bit act, int d, int unsigned v);
        if (act) act_head[d] = v;
        else inact_head[d] = v;
    endfunction

    function void push_front(bit act, int d, int unsigned i);
        int unsigned h;
        h = head_of(act, d);
        nxt[i] = h;
        prv[i] = ENDM;
        prv[h] = i;
        set_head(act, d, i);
    endfunction

    function void unlink(bit act, int d, int unsigned i);
        int unsigned nx;
        int unsigned pv;
        nx = nxt[i];
        if (head_of(act, d) == i) begin
            prv[nx] = ENDM;
            set_head(act, d, nx);
        end else begin
            pv = prv[i];
            nxt[pv] = nx;
            prv[nx] = pv;
        end
    endfunction

    function void add_act(int d, int unsigned u);
        push_front(1, d, u);
        mbr[u] = prbe_pkg::MB_ACT;
        if (d > top_act) top_act = d;
        if (top_used < top_act) top_used = top_act;
    endfunction

    function void add_inact(int d, int unsigned u);
        push_front(0, d, u);
        mbr[u] = prbe_pkg::MB_INACT;
    endfunction

    function void rescan_top();
        while (top_act >= 0 && act_head[top_act] == ENDM) top_act--;
    endfunction

    function int unsigned wipe(int unsigned h, int unsigned inf);
        int unsigned cnt;
        int unsigned i;
        cnt = 0;
        i = h;
        while (i != ENDM && cnt <= NN) begin
            lvl[i] = inf;
            written[i] = 1;
            mbr[i] = prbe_pkg::MB_NONE;
            cnt++;
            i = nxt[i];
        end
        return cnt;
    endfunction

    function int unsigned relabel(int unsigned u, int unsigned d);
        int unsigned inf;
        int unsigned gap;
        int unsigned cnt;
        inf = eff_inf();
        gap = lvl[u];
        cnt = 0;
        unlink(0, gap, u);
        mbr[u] = prbe_pkg::MB_NONE;
        lvl[u] = d;
        if (act_head[gap] == ENDM && inact_head[gap] == ENDM) begin
            lvl[u] = inf;
            cnt = 1;
            for (int lv = gap + 1; lv <= top_used && lv < NL; lv++) begin
                cnt += wipe(act_head[lv], inf);
                cnt += wipe(inact_head[lv], inf);
                act_head[lv] = ENDM;
                inact_head[lv] = ENDM;
            end
            top_used = int'(gap) - 1;
            if (top_act >= top_used) begin
                top_act = top_used;
                rescan_top();
            end
            if (int'(cnt) > incl) incl = 0;
            else incl -= cnt;
            gaps_seen++;
        end else if (d < inf) begin
            add_inact(d, u);
            if (top_used < int'(d)) top_used = d;
        end else if (incl > 0) begin
            incl--;
        end
        return cnt;
    endfunction

    function void clear_all();
        int unsigned sink;
        sink = eff_nodes() - 1;
        for (int i = 0; i < NL; i++) begin
            act_head[i] = ENDM;
            inact_head[i] = ENDM;
        end
        for (int i = 0; i < NN; i++) mbr[i] = prbe_pkg::MB_NONE;
        nxt[ENDM] = ENDM;
        prv[ENDM] = ENDM;
        top_act = -1;
        top_used = -1;
        lvl[sink] = 0;
        written[sink] = 1;
        add_inact(0, sink);
        incl = 2;
    endfunction

    function void note_command(prbe_pkg::t_cmd cmd, int unsigned u, int unsigned nl, bit ex);
        bucket_result_t r;
        int unsigned n;
        int unsigned inf;
        n = eff_nodes();
        inf = eff_inf();
        r = '0;
        if (cmd == prbe_pkg::CMD_CLEAR) begin
            clear_all();
        end else if (cmd == prbe_pkg::CMD_PEEK) begin
            if (top_act >= 0 && act_head[top_act] != ENDM) begin
                r.max_active_node = act_head[top_act];
            end else begin
                r.empty_res = 1;
                empties_seen++;
            end
        end else if (cmd != prbe_pkg::CMD_NOP && u < n) begin
            case (cmd)
                prbe_pkg::CMD_LOAD: begin
                    if (u + 2 < n && mbr[u] == prbe_pkg::MB_NONE) begin
                        lvl[u] = nl;
                        written[u] = 1;
                        if (nl < inf) begin
                            incl++;
                            if (int'(nl) > top_used) top_used = nl;
                            if (ex) add_act(nl, u);
                            else add_inact(nl, u);
                        end
                    end
                end
                prbe_pkg::CMD_ACT: begin
                    if (mbr[u] == prbe_pkg::MB_INACT) begin
                        unlink(0, lvl[u], u);
                        add_act(lvl[u], u);
                    end
                end
                prbe_pkg::CMD_DEACT: begin
                    if (mbr[u] == prbe_pkg::MB_ACT) begin
                        unlink(1, lvl[u], u);
                        rescan_top();
                        add_inact(lvl[u], u);
                    end
                end
                prbe_pkg::CMD_RELABEL: begin
                    if (mbr[u] == prbe_pkg::MB_INACT) r.removed_count = relabel(u, nl);
                end
                default: r.level_value = lvl[u];
            endcase
        end
        r.any_active = (top_act > 0);
        r.included_count = (incl < 0) ? 0 : incl;
        expected_results.push_back(r);
    endfunction

    function void check_result(bucket_result_t got);
        bucket_result_t exp_r;
        results_seen++;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d mismatch: expected %p, got %p", results_seen, exp_r, got);
        end
    endfunction
endclass

module tb_push_relabel_bucket_engine_core;
    timeunit 1ns;
    timeprecision 1ps;
    import prbe_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;
    bit calm;
    int idle_cycles;
    int items_sent;
    int phases_run;
    int pool[$];

    prbe_in_if  in_ch();
    prbe_out_if out_ch();
    prbe_scoreboard bucket_sb;

    push_relabel_bucket_engine_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        bucket_sb = new();
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_IDX_NODES;
        i_cfg_wdata = '0;
        in_ch.valid = 0;
        in_ch.cmd = CMD_NOP;
        in_ch.node = '0;
        in_ch.new_level = '0;
        in_ch.has_excess = 0;
        out_ch.ready = 0;
    end

    // result side: random backpressure and checking
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            bucket_sb.check_result({out_ch.max_active_node, out_ch.empty_res, out_ch.any_active,
                                    out_ch.removed_count, out_ch.level_value,
                                    out_ch.included_count});
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000) begin
            $display("timeout waiting for a transfer");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // entered and left in the time step of a rising edge
    task automatic send_cmd(t_cmd cmd, int unsigned u, int unsigned nl, bit ex);
        if (!calm && $urandom_range(99) < 8) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.cmd <= cmd;
        in_ch.node <= u[NODE_W-1:0];
        in_ch.new_level <= nl[LVL_W-1:0];
        in_ch.has_excess <= ex;
        do @(posedge i_clk); while (!in_ch.ready);
        bucket_sb.note_command(cmd, u, nl, ex);
        items_sent++;
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        in_ch.valid <= 0;
        while (bucket_sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_IDX_NODES) bucket_sb.cfg_nodes = val;
        else bucket_sb.cfg_inf = val;
    endtask

    function automatic int unsigned pick_node();
        int unsigned n;
        n = bucket_sb.eff_nodes();
        if ($urandom_range(99) < 8) return $urandom_range(1023);
        if (pool.size() != 0 && $urandom_range(99) < 80) return pool[$urandom_range(pool.size() - 1)];
        return $urandom_range(n - 1);
    endfunction

    task automatic load_pool(int want);
        int unsigned n;
        int unsigned u;
        n = bucket_sb.eff_nodes();
        pool.delete();
        send_cmd(CMD_CLEAR, 0, 0, 0);
        for (int k = 0; k < want && n > 2; k++) begin
            u = (n <= 34) ? k % (n - 2) : $urandom_range(n - 3);
            pool.push_back(u);
            send_cmd(CMD_LOAD, u, $urandom_range(bucket_sb.eff_inf() - 1), $urandom_range(1));
        end
        pool.push_back(n - 1);
    endtask

    task automatic random_items(int count);
        int unsigned u;
        int unsigned nl;
        int unsigned inf;
        int w;
        t_cmd cmd;
        for (int k = 0; k < count; k++) begin
            u = pick_node();
            inf = bucket_sb.eff_inf();
            w = $urandom_range(99);
            if (w < 18) cmd = CMD_ACT;
            else if (w < 36) cmd = CMD_DEACT;
            else if (w < 58) cmd = CMD_RELABEL;
            else if (w < 72) cmd = CMD_PEEK;
            else if (w < 82) cmd = CMD_RDLVL;
            else if (w < 90) cmd = CMD_LOAD;
            else if (w < 92) cmd = CMD_CLEAR;
            else cmd = t_cmd'($urandom_range(7));
            if (u < bucket_sb.NN && bucket_sb.mbr[u] == MB_INACT && $urandom_range(99) < 70)
                nl = bucket_sb.lvl[u] + $urandom_range(2);
            else if ($urandom_range(99) < 15)
                nl = $urandom_range(2047);
            else
                nl = $urandom_range(inf);
            // never read the level of a node that was never written
            if (cmd == CMD_RDLVL && u < bucket_sb.eff_nodes() && !bucket_sb.written[u])
                cmd = CMD_PEEK;
            send_cmd(cmd, u, nl, $urandom_range(1));
        end
    endtask

    task automatic run_phase(int unsigned nodes, int unsigned inf, int loads, int count);
        write_reg(CFG_IDX_NODES, nodes);
        write_reg(CFG_IDX_INF, inf);
        phases_run++;
        load_pool(loads);
        random_items(count);
    endtask

    initial begin
        idle_cycles = 0;
        items_sent = 0;
        phases_run = 0;
        calm = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_reg(CFG_IDX_NODES, 16);
        write_reg(CFG_IDX_INF, 8);
        phases_run++;
        send_cmd(CMD_PEEK, 0, 0, 0);
        send_cmd(CMD_CLEAR, 0, 0, 0);
        send_cmd(CMD_PEEK, 0, 0, 0);
        send_cmd(CMD_RDLVL, 15, 0, 0);
        send_cmd(CMD_LOAD, 0, 0, 1);
        send_cmd(CMD_LOAD, 1, 2, 0);
        send_cmd(CMD_LOAD, 2, 2, 0);
        send_cmd(CMD_LOAD, 3, 5, 1);
        send_cmd(CMD_LOAD, 4, 8, 1);
        send_cmd(CMD_LOAD, 14, 1, 1);
        send_cmd(CMD_PEEK, 0, 0, 0);
        send_cmd(CMD_ACT, 1, 0, 0);
        send_cmd(CMD_PEEK, 0, 0, 0);
        send_cmd(CMD_DEACT, 1, 0, 0);
        send_cmd(CMD_DEACT, 3, 0, 0);
        // two nodes share level 2, so the first relabel leaves no gap
        send_cmd(CMD_RELABEL, 2, 4, 0);
        send_cmd(CMD_RELABEL, 1, 9, 0);
        send_cmd(CMD_RELABEL, 2, 3, 0);
        send_cmd(CMD_RDLVL, 3, 0, 0);
        send_cmd(CMD_RDLVL, 4, 0, 0);
        send_cmd(CMD_ACT, 1023, 0, 0);
        send_cmd(CMD_NOP, 5, 5, 1);
        send_cmd(CMD_PEEK, 0, 0, 0);
        pool = '{0, 1, 2, 3, 4, 15};
        random_items(90);

        calm = 1;
        run_phase(2047, 2047, 30, 70);
        calm = 0;
        run_phase(0, 0, 0, 30);
        run_phase(6, 3, 4, 90);
        run_phase(40, 1024, 20, 70);
        run_phase(1, 1, 0, 10);
        run_phase(24, 12, 22, 60);

        in_ch.valid <= 0;
        while (bucket_sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (bucket_sb.expected_results.size() != 0) bucket_sb.mismatches++;
        $display("%0d commands over %0d register settings, %0d results checked",
                 items_sent, phases_run, bucket_sb.results_seen);
        $display("%0d gap relabels, %0d empty peeks, %0d mismatches",
                 bucket_sb.gaps_seen, bucket_sb.empties_seen, bucket_sb.mismatches);
        if (bucket_sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
